// ----- hw/rtl/trp_pkg.sv -----
// ----------------------------------------------------------------------------
// Time-proportioning relay package
// Widths, codes and the structs shared by the relay driver modules.
// ----------------------------------------------------------------------------
package trp_pkg;

  localparam int unsigned PeriodW  = 24;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned OpW      = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned ProdW    = PeriodW + LevelW;
  localparam int unsigned ThrW     = ProdW + 1;

  localparam logic [PeriodW-1:0] DefaultPeriod = PeriodW'(5000);
  localparam logic [LevelW-1:0]  FullLevel     = LevelW'(255);

  typedef enum logic [OpW-1:0] {
    OP_TICK        = 2'd0,
    OP_SET_LEVEL   = 2'd1,
    OP_COMMAND_ON  = 2'd2,
    OP_COMMAND_OFF = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PERIOD_MS     = 1'd0,
    CFG_INVERT_OUTPUT = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    op_e               operation;
    logic [LevelW-1:0] level;
  } item_t;

  typedef struct packed {
    logic               we;
    cfg_idx_e           index;
    logic [PeriodW-1:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic pin_level;
    logic relay_on;
    logic cycle_running;
  } result_t;

endpackage

// ----- hw/rtl/time_proportioning_relay.sv -----
// ----------------------------------------------------------------------------
// Time-proportioning relay driver
// Slow PWM: the relay is on for period * duty / 255 ms of each cycle.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the input side is not
// stalled and returns exactly one result transfer per item. Each item is
// held in the input register until the core steps on it; the core then
// updates the cycle state and writes the result queue. Up to two results can
// wait on the output; the input side stalls only when both are held and the
// consumer is not taking one. A tick item stands for one millisecond. Each
// result reports the pin drive (relay state with the configured polarity),
// the logical relay state and whether a proportioning cycle is running, all
// as they stand after that item. The on time is never divided out: the core
// keeps period * duty in a register and compares it against 255 times the
// elapsed count plus one, giving the same decision as the integer quotient.
// Configuration writes (period in ms, where zero means 5000, and output
// inversion) are always accepted and take effect at the next cycle; they are
// meant to arrive while no item is in flight.
// ----------------------------------------------------------------------------
module time_proportioning_relay (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [trp_pkg::OpW-1:0]       operation_i,
  input  logic [trp_pkg::LevelW-1:0]    level_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          pin_level_o,
  output logic                          relay_on_o,
  output logic                          cycle_running_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [trp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [trp_pkg::PeriodW-1:0]   cfg_value_i
);
  import trp_pkg::*;

  item_t   in_item;
  item_t   core_item;
  cfg_wr_t cfg_wr;
  result_t core_result;
  result_t out_result;
  logic    step;
  logic    room;

  // Configuration writes never stall.
  assign cfg_ready_o   = 1'b1;
  assign cfg_wr.we     = cfg_valid_i;
  assign cfg_wr.index  = cfg_idx_e'(cfg_index_i);
  assign cfg_wr.value  = cfg_value_i;

  assign in_item.operation = op_e'(operation_i);
  assign in_item.level     = level_i;

  trp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .room_i     (room),
    .step_o     (step),
    .item_o     (core_item)
  );

  // The core steps on the held item only when the result queue can take
  // the result in the same cycle.
  trp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_wr),
    .step_i   (step),
    .item_i   (core_item),
    .result_o (core_result)
  );

  trp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .result_i    (core_result),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_result)
  );

  assign pin_level_o     = out_result.pin_level;
  assign relay_on_o      = out_result.relay_on;
  assign cycle_running_o = out_result.cycle_running;

endmodule

// ----- hw/rtl/trp_in_stage.sv -----
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted item until the core can step on it.
// ----------------------------------------------------------------------------
module trp_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  trp_pkg::item_t item_i,
  input  logic          room_i,
  output logic          step_o,
  output trp_pkg::item_t item_o
);
  import trp_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  assign step_o     = valid_q & room_i;
  assign in_ready_o = ~valid_q | step_o;
  assign load       = in_valid_i & in_ready_o;
  assign valid_d    = load | (valid_q & ~step_o);
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

endmodule

// ----- hw/rtl/trp_core.sv -----
// ----------------------------------------------------------------------------
// Relay core
// Cycle state, configuration registers and the per-item update.
// ----------------------------------------------------------------------------
module trp_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  trp_pkg::cfg_wr_t cfg_i,
  input  logic             step_i,
  input  trp_pkg::item_t   item_i,
  output trp_pkg::result_t result_o
);
  import trp_pkg::*;

  logic [PeriodW-1:0] period_q, period_d;
  logic               invert_q, invert_d;
  logic [PeriodW-1:0] elapsed_q, elapsed_d;
  logic               running_q, running_d;
  logic               relay_q, relay_d;
  logic [LevelW-1:0]  duty_q, duty_d;
  logic               active_q, active_d;
  logic [ProdW-1:0]   prod_q, prod_d;

  logic [PeriodW-1:0] elapsed_inc;
  logic [PeriodW:0]   elapsed_plus1;
  logic [ThrW-1:0]    thr;
  logic               wrap;
  logic               past_on;

  // The on time is floor(period * duty / 255). Elapsed is at or past it
  // exactly when period * duty < 255 * (elapsed + 1), so no divider is needed;
  // the product is kept in a register that follows duty and period.
  assign elapsed_inc   = (elapsed_q < period_q) ? elapsed_q + PeriodW'(1) : period_q;
  assign elapsed_plus1 = {1'b0, elapsed_inc} + (PeriodW+1)'(1);
  assign thr           = ThrW'(elapsed_plus1) * ThrW'(FullLevel);
  assign wrap          = (elapsed_inc == period_q);
  assign past_on       = ({1'b0, prod_q} < thr);

  always_comb begin
    period_d  = period_q;
    invert_d  = invert_q;
    elapsed_d = elapsed_q;
    running_d = running_q;
    relay_d   = relay_q;
    duty_d    = duty_q;
    active_d  = active_q;

    if (cfg_i.we) begin
      unique case (cfg_i.index)
        CFG_PERIOD_MS: begin
          period_d = (cfg_i.value == '0) ? DefaultPeriod : cfg_i.value;
        end
        CFG_INVERT_OUTPUT: begin
          invert_d = cfg_i.value[0];
        end
      endcase
    end

    if (step_i) begin
      unique case (item_i.operation)
        OP_TICK: begin
          if (running_q) begin
            if (wrap) begin
              elapsed_d = '0;
              if (duty_q != '0) begin
                relay_d = 1'b1;
              end
            end else begin
              elapsed_d = elapsed_inc;
              if (relay_q && past_on) begin
                relay_d = 1'b0;
                if (!active_q) begin
                  running_d = 1'b0;
                end
              end else if (duty_q != '0 && !relay_q && !past_on) begin
                relay_d = 1'b1;
              end
            end
          end
        end
        OP_SET_LEVEL: begin
          duty_d = item_i.level;
          if (item_i.level != '0) begin
            active_d = 1'b1;
            if (!running_q) begin
              running_d = 1'b1;
              elapsed_d = '0;
            end
          end else begin
            running_d = 1'b0;
            relay_d   = 1'b0;
            active_d  = 1'b0;
          end
        end
        OP_COMMAND_ON: begin
          active_d = 1'b1;
          if (!running_q) begin
            running_d = 1'b1;
            elapsed_d = '0;
          end
        end
        OP_COMMAND_OFF: begin
          running_d = 1'b0;
          relay_d   = 1'b0;
          active_d  = 1'b0;
        end
      endcase
    end
  end

  assign prod_d = ProdW'(period_d) * ProdW'(duty_d);

  assign result_o.pin_level     = relay_d ^ invert_q;
  assign result_o.relay_on      = relay_d;
  assign result_o.cycle_running = running_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= DefaultPeriod;
      invert_q  <= 1'b0;
      elapsed_q <= '0;
      running_q <= 1'b0;
      relay_q   <= 1'b0;
      duty_q    <= '0;
      active_q  <= 1'b0;
      prod_q    <= '0;
    end else begin
      period_q  <= period_d;
      invert_q  <= invert_d;
      elapsed_q <= elapsed_d;
      running_q <= running_d;
      relay_q   <= relay_d;
      duty_q    <= duty_d;
      active_q  <= active_d;
      prod_q    <= prod_d;
    end
  end

endmodule

// ----- hw/rtl/trp_out_buf.sv -----
// ----------------------------------------------------------------------------
// Result buffer
// Two-entry result queue that decouples the core from output stalls.
// ----------------------------------------------------------------------------
module trp_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  trp_pkg::result_t result_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output trp_pkg::result_t result_o
);
  import trp_pkg::*;

  result_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o & out_ready_i;
  assign room_o      = (cnt_q != 2'd2) | pop;
  assign result_o    = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= result_i;
    end
  end

endmodule

// ----- hw/rtl/trp_checker.sv -----
// ----------------------------------------------------------------------------
// Relay port checker
// Port-level properties of the time-proportioning relay driver.
// ----------------------------------------------------------------------------
module trp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic pin_level_o,
  input logic relay_on_o,
  input logic cycle_running_o
);

  // An energized relay always belongs to a running cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && relay_on_o |-> cycle_running_o)
    else $error("relay reported on without a running cycle");

  // The input side stalls only when held results are not being taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while the output can move");

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(pin_level_o) && $stable(relay_on_o) && $stable(cycle_running_o))
    else $error("result changed while stalled");

endmodule

bind time_proportioning_relay trp_checker u_trp_checker (.*);
